// ===== rtl/core/psmap_pkg.sv =====
// Shared widths, constants and types of the polygon second moment block.
package psmap_pkg;

  localparam int unsigned CoordW     = 17;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ScaleShift = (4 * FracBits > 32) ? (4 * FracBits - 32) : 0;
  localparam int unsigned DiffW      = CoordW + 1;
  localparam int unsigned Len2W      = 2 * CoordW + 2;
  localparam int unsigned CrossW     = Len2W + 1;
  localparam int unsigned MulW       = 39;
  localparam int unsigned ProdW      = 2 * MulW;
  localparam int unsigned AccW       = 112;
  localparam int unsigned QuotW      = 41;
  localparam int unsigned DenBaseW   = Len2W + 3;
  localparam int unsigned DenW       = DenBaseW + ScaleShift;
  localparam int unsigned SumW       = 36;
  localparam int unsigned CntW       = 6;

  localparam logic [QuotW-1:0] TermClamp = QuotW'(1) << 40;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/psmap_div.sv =====
// Restoring divider, one quotient bit per cycle, with clamp of the edge term.
module psmap_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [psmap_pkg::AccW-1:0]       num_i,
  input  logic [psmap_pkg::DenW-1:0]       den_i,
  output logic [psmap_pkg::QuotW-1:0]      quot_o,
  output psmap_pkg::div_stat_t             stat_o
);

  logic [psmap_pkg::DenW-1:0]  rem_q, den_q;
  logic [psmap_pkg::QuotW-1:0] nlo_q, quot_q;
  logic [psmap_pkg::CntW-1:0]  cnt_q;
  logic                        ovf_q, busy_q, done_q;
  logic [psmap_pkg::DenW:0]    trial;
  logic                        ge;

  assign trial = {rem_q, nlo_q[psmap_pkg::QuotW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (start_i) begin
        den_q  <= den_i;
        quot_q <= '0;
        nlo_q  <= num_i[psmap_pkg::QuotW-1:0];
        rem_q  <= num_i[psmap_pkg::AccW-1:psmap_pkg::QuotW];
        // A quotient of 2^41 or more is clamped without iterating.
        if (num_i[psmap_pkg::AccW-1:psmap_pkg::QuotW] >= den_i) begin
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          ovf_q  <= 1'b0;
          done_q <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= psmap_pkg::CntW'(psmap_pkg::QuotW);
        end
      end else if (busy_q) begin
        rem_q  <= ge ? psmap_pkg::DenW'(trial - {1'b0, den_q})
                     : trial[psmap_pkg::DenW-1:0];
        nlo_q  <= {nlo_q[psmap_pkg::QuotW-2:0], 1'b0};
        quot_q <= {quot_q[psmap_pkg::QuotW-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == psmap_pkg::CntW'(1));
        if (cnt_q == psmap_pkg::CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign quot_o = (ovf_q || quot_q > psmap_pkg::TermClamp) ? psmap_pkg::TermClamp : quot_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/polygon_second_moment_about_point.sv =====
// Top level: accumulates the signed second moment of a polygon about a point.
//
// Usage: polygon vertices arrive counter-clockwise on the slave stream, one per
// transaction, each with the reference point; tlast marks the final vertex.
// The first vertex of a polygon opens a new sum. Every later vertex adds the
// edge from the previous vertex, and the final one also adds the closing edge
// back to the first vertex, then emits one result transaction carrying the
// saturated Q3.32 sum in tdata and the clip flag in tuser.
// One 39x39 multiplier with a registered product computes all edge products
// in turn, then a restoring divider forms the edge term; a final vertex runs
// this for its own edge and then for the closing edge before the output register
// is loaded. Edges of zero length or collinear with the point skip the
// remaining products and the division. s_axis_tready is high only when
// the sequencer is idle. The result sits in an output register; if the
// receiver stalls, the next polygon's items are still taken and processing
// only waits when a new result is ready while the old one is still held.
// Reset empties the output register and starts a fresh polygon.
module polygon_second_moment_about_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // point_x, point_y, vertex_x, vertex_y, zero pad
  input  logic        s_axis_tlast,  // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // moment_sum, zero pad
  output logic        m_axis_tuser   // saturated
);

  localparam int unsigned CW = psmap_pkg::CoordW;

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_DIFF = 5'd1,  ST_LA   = 5'd2,
                         ST_LB   = 5'd3,  ST_LC   = 5'd4,  ST_LEN  = 5'd5,
                         ST_CA   = 5'd6,  ST_CB   = 5'd7,  ST_CEND = 5'd8,
                         ST_EA   = 5'd9,  ST_EB   = 5'd10, ST_EEND = 5'd11,
                         ST_QA   = 5'd12, ST_QB   = 5'd13, ST_QC   = 5'd14,
                         ST_QEND = 5'd15, ST_NA   = 5'd16, ST_NB   = 5'd17,
                         ST_DIVS = 5'd18, ST_DIVW = 5'd19, ST_ADD  = 5'd20,
                         ST_NEXT = 5'd21, ST_EMIT = 5'd22;

  logic [4:0] state_q, state_d;

  logic [CW-1:0] px_q, py_q, vx_q, vy_q, fx_q, fy_q, prx_q, pry_q;
  logic          last_q, closing_q, have_first_q;
  logic signed [psmap_pkg::DiffW-1:0] dx_q, dy_q, wx_q, wy_q;
  logic [psmap_pkg::Len2W-1:0]        len2_q, cmag_q;
  logic [psmap_pkg::CrossW-1:0]       c_q, e1_q;
  logic [psmap_pkg::CrossW:0]         e2_q;
  logic signed [psmap_pkg::AccW-1:0]  acc_q;
  logic signed [psmap_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [psmap_pkg::MulW-1:0]  op_a, op_b;
  logic [psmap_pkg::SumW-1:0]         sum_q;
  logic                               clip_q;
  logic [psmap_pkg::SumW-1:0]         out_sum_q;
  logic                               out_clip_q, out_valid_q;

  logic [CW-1:0] ax, ay, bx, by;
  logic signed [psmap_pkg::AccW-1:0] pext, p3, p38, neg_acc;
  logic [psmap_pkg::DenBaseW-1:0]    den_base;
  logic [psmap_pkg::DenW-1:0]        den;
  logic [psmap_pkg::AccW-1:0]        num;
  logic [psmap_pkg::QuotW-1:0]       quot;
  psmap_pkg::div_stat_t              div_stat;
  logic [psmap_pkg::SumW+6:0]        term, total;
  logic                              in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Edge endpoints: the item edge runs from the previous vertex, the closing
  // edge from the current vertex back to the first one.
  assign ax = closing_q ? vx_q : prx_q;
  assign ay = closing_q ? vy_q : pry_q;
  assign bx = closing_q ? fx_q : vx_q;
  assign by = closing_q ? fy_q : vy_q;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_LA:   begin op_a = 39'(dx_q); op_b = 39'(dx_q); end
      ST_LB:   begin op_a = 39'(dy_q); op_b = 39'(dy_q); end
      ST_LEN:  begin op_a = 39'(dx_q); op_b = 39'(wy_q); end
      ST_CA:   begin op_a = 39'(dy_q); op_b = 39'(wx_q); end
      ST_CEND: begin op_a = 39'(dx_q); op_b = 39'(wx_q); end
      ST_EA:   begin op_a = 39'(dy_q); op_b = 39'(wy_q); end
      ST_EEND: begin op_a = {3'b0, len2_q}; op_b = {3'b0, len2_q}; end
      ST_QA:   begin op_a = {{2{c_q[36]}}, c_q}; op_b = {{2{c_q[36]}}, c_q}; end
      ST_QB:   begin op_a = {{2{e1_q[36]}}, e1_q}; op_b = {e2_q[37], e2_q}; end
      ST_QEND: begin op_a = {1'b0, acc_q[37:0]}; op_b = {3'b0, cmag_q}; end
      ST_NA:   begin op_a = {1'b0, acc_q[75:38]}; op_b = {3'b0, cmag_q}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_d  = op_a * op_b;
  assign pext    = {{(psmap_pkg::AccW - psmap_pkg::ProdW){prod_q[psmap_pkg::ProdW-1]}}, prod_q};
  assign p3      = pext + {pext[psmap_pkg::AccW-2:0], 1'b0};
  assign p38     = {pext[psmap_pkg::AccW-39:0], 38'b0};
  assign neg_acc = -acc_q;

  assign den_base = {len2_q, 3'b0} + {1'b0, len2_q, 2'b0};
  assign den      = {den_base, {psmap_pkg::ScaleShift{1'b0}}};
  // Adding half the divisor rounds the magnitude to nearest, halves up.
  assign num      = acc_q + {{(psmap_pkg::AccW - psmap_pkg::DenW){1'b0}}, 1'b0,
                             den[psmap_pkg::DenW-1:1]};

  psmap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIVS),
    .num_i   (num),
    .den_i   (den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  assign term  = c_q[36] ? -{2'b0, quot} : {2'b0, quot};
  assign total = {{7{sum_q[35]}}, sum_q} + term;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = have_first_q ? ST_DIFF : ST_NEXT;
      ST_DIFF: state_d = ST_LA;
      ST_LA:   state_d = ST_LB;
      ST_LB:   state_d = ST_LC;
      ST_LC:   state_d = ST_LEN;
      ST_LEN:  state_d = (acc_q == '0) ? ST_NEXT : ST_CA;
      ST_CA:   state_d = ST_CB;
      ST_CB:   state_d = ST_CEND;
      ST_CEND: state_d = (acc_q == '0) ? ST_NEXT : ST_EA;
      ST_EA:   state_d = ST_EB;
      ST_EB:   state_d = ST_EEND;
      ST_EEND: state_d = ST_QA;
      ST_QA:   state_d = ST_QB;
      ST_QB:   state_d = ST_QC;
      ST_QC:   state_d = ST_QEND;
      ST_QEND: state_d = ST_NA;
      ST_NA:   state_d = ST_NB;
      ST_NB:   state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_stat.done) state_d = ST_ADD;
      ST_ADD:  state_d = ST_NEXT;
      ST_NEXT: begin
        if (last_q && !closing_q) state_d = ST_DIFF;
        else if (last_q)          state_d = ST_EMIT;
        else                      state_d = ST_IDLE;
      end
      ST_EMIT: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      have_first_q <= 1'b0;
      closing_q    <= 1'b0;
      last_q       <= 1'b0;
      sum_q        <= '0;
      clip_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      fx_q         <= '0;
      fy_q         <= '0;
      prx_q        <= '0;
      pry_q        <= '0;
    end else begin
      state_q <= state_d;
      // The emit step reloads the output register itself.
      if (out_valid_q && m_axis_tready && state_q != ST_EMIT) out_valid_q <= 1'b0;
      unique case (state_q) inside
        ST_IDLE: begin
          if (in_fire) begin
            px_q      <= s_axis_tdata[16:0];
            py_q      <= s_axis_tdata[33:17];
            vx_q      <= s_axis_tdata[50:34];
            vy_q      <= s_axis_tdata[67:51];
            last_q    <= s_axis_tlast;
            closing_q <= 1'b0;
            if (!have_first_q) begin
              fx_q         <= s_axis_tdata[50:34];
              fy_q         <= s_axis_tdata[67:51];
              have_first_q <= 1'b1;
              sum_q        <= '0;
              clip_q       <= 1'b0;
            end
          end
        end
        ST_DIFF: begin
          dx_q <= $signed({1'b0, bx}) - $signed({1'b0, ax});
          dy_q <= $signed({1'b0, by}) - $signed({1'b0, ay});
          wx_q <= $signed({1'b0, px_q}) - $signed({1'b0, ax});
          wy_q <= $signed({1'b0, py_q}) - $signed({1'b0, ay});
        end
        ST_LB, ST_CA, ST_EA, ST_QA, ST_NA: acc_q <= pext;
        ST_LC, ST_EB: acc_q <= acc_q + pext;
        ST_CB: acc_q <= acc_q - pext;
        ST_QB: acc_q <= acc_q + p3;
        ST_QC: acc_q <= acc_q - p3;
        ST_NB: acc_q <= acc_q + p38;
        ST_LEN:  len2_q <= acc_q[psmap_pkg::Len2W-1:0];
        ST_CEND: begin
          c_q    <= acc_q[psmap_pkg::CrossW-1:0];
          cmag_q <= acc_q[psmap_pkg::AccW-1] ? neg_acc[psmap_pkg::Len2W-1:0]
                                             : acc_q[psmap_pkg::Len2W-1:0];
        end
        ST_EEND: begin
          e1_q <= acc_q[psmap_pkg::CrossW-1:0];
          e2_q <= {2'b0, len2_q} - acc_q[psmap_pkg::CrossW:0];
        end
        ST_ADD: begin
          // Saturate when the top bits are not a sign extension.
          if (total[42:35] != 8'h00 && total[42:35] != 8'hFF) begin
            sum_q  <= total[42] ? {1'b1, 35'b0} : {1'b0, {35{1'b1}}};
            clip_q <= 1'b1;
          end else begin
            sum_q <= total[psmap_pkg::SumW-1:0];
          end
        end
        ST_NEXT: begin
          prx_q <= vx_q;
          pry_q <= vy_q;
          if (last_q && !closing_q) closing_q <= 1'b1;
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_sum_q    <= sum_q;
            out_clip_q   <= clip_q;
            out_valid_q  <= 1'b1;
            have_first_q <= 1'b0;
            sum_q        <= '0;
            clip_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_sum_q};
  assign m_axis_tuser  = out_clip_q;

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_EMIT)
    else $error("result appeared outside the emit step");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIVW)
    else $error("divider finished while not awaited");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("ready while the divider is still busy");

endmodule
